// File: rtl/bdh_pkg.sv
// Shared types and constants for the burst duration histogram.
`default_nettype none

package bdh_pkg;

   // Field widths of the request and response beats.
   localparam int SAMPLE_W    = 15;
   localparam int INDEX_W     = 10;
   localparam int LENGTH_W    = 10;
   localparam int COUNT_W     = 32;
   localparam int REBIN_W     = 9;
   localparam int THRESH_W    = 23;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 23;

   // Saturation limits of the aggregate sum and the histogram counters.
   localparam logic [THRESH_W-1:0] POOL_MAX  = '1;
   localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;

   // Register indexes on the configuration port.
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_REBIN_FACTOR    = 1'b0;
   localparam csr_index_type CSR_COUNT_THRESHOLD = 1'b1;

   // Request command codes.
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   typedef struct packed {
      logic                command;
      logic [SAMPLE_W-1:0] sample_count;
      logic [INDEX_W-1:0]  bin_index;
   } req_type;

   typedef struct packed {
      logic                event_done;
      logic [LENGTH_W-1:0] event_length;
      logic                length_overflow;
      logic [COUNT_W-1:0]  bin_count;
   } rsp_type;

   // Work handed from the classifier to the histogram engine.
   typedef enum logic [1:0] {
      OP_BLANK,
      OP_RECORD,
      OP_READ
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic        overflow;
      logic        open_hit;
   } op_type;

endpackage

`default_nettype wire

// File: rtl/bdh_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module bdh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; a read that meets a write returns the old word.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/bdh_fifo.sv
// Small register based first-in first-out queue.
`default_nettype none

module bdh_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty,
   output logic                  full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update; pointers wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/bdh_front.sv
// Front end: configuration, aggregate pooling and event classification.
`default_nettype none

module bdh_front #(
   parameter int HIST_DEPTH = 1024,
   parameter int MAX_REBIN  = 256,
   localparam int AW = $clog2(HIST_DEPTH)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_en,
   input  wire bdh_pkg::csr_index_type            csr_index,
   input  wire logic [bdh_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic                              accept,
   input  wire bdh_pkg::req_type                  req,
   output bdh_pkg::op_type                        op,
   output logic      [AW-1:0]                     op_addr
);

   import bdh_pkg::*;

   localparam int RW = $clog2(HIST_DEPTH + 1);
   localparam int BW = $clog2(MAX_REBIN + 1);

   logic [REBIN_W-1:0]  rebin_ff, rebin_in;
   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic [THRESH_W-1:0] pool_ff, pool_in;
   logic [BW-1:0]       left_ff, left_in;
   logic                inside_ff, inside_in;
   logic [RW-1:0]       run_ff, run_in;

   logic [THRESH_W:0]   sum;
   logic [THRESH_W-1:0] pool_sat;
   logic [BW-1:0]       left_dec;
   logic [RW-1:0]       run_clamp;
   logic                above;

   // Rebin factor as used: zero counts as one, large values are capped.
   function automatic logic [BW-1:0] eff_rebin(input logic [REBIN_W-1:0] rf);
      logic [BW-1:0] res;
      if (rf == '0) begin
         res = BW'(1);
      end else if (32'(rf) > 32'(MAX_REBIN)) begin
         res = BW'(MAX_REBIN);
      end else begin
         res = BW'(rf);
      end
      return res;
   endfunction

   // Saturating aggregate sum and the length of the open event so far.
   always_comb begin
      sum       = (THRESH_W + 1)'(pool_ff) + (THRESH_W + 1)'(req.sample_count);
      pool_sat  = sum[THRESH_W] ? POOL_MAX : sum[THRESH_W-1:0];
      left_dec  = (left_ff != '0) ? left_ff - BW'(1) : '0;
      run_clamp = (run_ff == RW'(HIST_DEPTH)) ? RW'(HIST_DEPTH - 1) : run_ff;
      above     = (pool_sat > thresh_ff);
   end

   // Next state and the operation passed to the histogram engine.
   always_comb begin
      rebin_in  = rebin_ff;
      thresh_in = thresh_ff;
      pool_in   = pool_ff;
      left_in   = left_ff;
      inside_in = inside_ff;
      run_in    = run_ff;
      op        = '{kind: OP_BLANK, overflow: 1'b0, open_hit: 1'b0};
      op_addr   = '0;
      if (csr_write_en) begin
         case (csr_index)
            CSR_REBIN_FACTOR: begin
               rebin_in = csr_data[REBIN_W-1:0];
               pool_in  = '0;
               left_in  = eff_rebin(csr_data[REBIN_W-1:0]);
            end
            CSR_COUNT_THRESHOLD: begin
               thresh_in = csr_data[THRESH_W-1:0];
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (req.command == CMD_READ) begin
            // Reads beyond the store give a zero count.
            if (32'(req.bin_index) < 32'(HIST_DEPTH)) begin
               op.kind     = OP_READ;
               op_addr     = AW'(req.bin_index);
               op.open_hit = inside_ff && (32'(run_clamp) == 32'(req.bin_index));
            end
         end else begin
            pool_in = pool_sat;
            left_in = left_dec;
            if (left_dec == '0) begin
               // The aggregate is complete: open, extend or close an event.
               if (!inside_ff && above) begin
                  inside_in = 1'b1;
                  run_in    = '0;
               end else if (inside_ff && !above) begin
                  op.kind     = OP_RECORD;
                  op_addr     = AW'(run_clamp);
                  op.overflow = (run_ff == RW'(HIST_DEPTH));
                  inside_in   = 1'b0;
                  run_in      = '0;
               end
               if (inside_in && run_in != RW'(HIST_DEPTH)) begin
                  run_in = run_in + RW'(1);
               end
               pool_in = '0;
               left_in = eff_rebin(rebin_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rebin_ff  <= REBIN_W'(1);
         thresh_ff <= '0;
         pool_ff   <= '0;
         left_ff   <= BW'(1);
         inside_ff <= 1'b0;
         run_ff    <= '0;
      end else begin
         rebin_ff  <= rebin_in;
         thresh_ff <= thresh_in;
         pool_ff   <= pool_in;
         left_ff   <= left_in;
         inside_ff <= inside_in;
         run_ff    <= run_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/bdh_back.sv
// Back end: histogram store, clearing sweep, read-modify-write and responses.
`default_nettype none

module bdh_back #(
   parameter int HIST_DEPTH = 1024,
   localparam int AW = $clog2(HIST_DEPTH)
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            mid_empty,
   input  wire bdh_pkg::op_type mid_op,
   input  wire logic [AW-1:0]   mid_addr,
   output logic                 mid_pop,
   input  wire logic            out_full,
   output logic                 out_push,
   output bdh_pkg::rsp_type     out_rsp,
   output logic                 clr_busy
);

   import bdh_pkg::*;

   logic               clr_busy_ff, clr_busy_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;
   logic               b_valid_ff, b_valid_in;
   op_type             b_op_ff;
   logic [AW-1:0]      b_addr_ff;
   logic               lw_valid_ff;
   logic [AW-1:0]      lw_addr_ff;
   logic [COUNT_W-1:0] lw_data_ff;

   logic               b_fire, b_load;
   logic [COUNT_W-1:0] ram_rd_data, cur, inc;
   logic               ram_we;
   logic [AW-1:0]      ram_wa;
   logic [COUNT_W-1:0] ram_wd;

   bdh_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (HIST_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (b_load),
      .rd_addr (mid_addr),
      .rd_data (ram_rd_data)
   );

   // Stage handshake: the stage reloads when empty or when its beat leaves.
   assign b_fire   = b_valid_ff && !out_full;
   assign b_load   = !clr_busy_ff && !mid_empty && (!b_valid_ff || b_fire);
   assign mid_pop  = b_load;
   assign out_push = b_fire;
   assign clr_busy = clr_busy_ff;

   // The last word written always matches the store, so it covers the
   // read that met that write in the same cycle.
   always_comb begin
      cur = (lw_valid_ff && lw_addr_ff == b_addr_ff) ? lw_data_ff : ram_rd_data;
      inc = (cur == COUNT_MAX) ? COUNT_MAX : cur + COUNT_W'(1);
   end

   // Response beat built from the operation in the stage.
   always_comb begin
      out_rsp = '0;
      case (b_op_ff.kind)
         OP_RECORD: begin
            out_rsp.event_done      = 1'b1;
            out_rsp.event_length    = LENGTH_W'(b_addr_ff);
            out_rsp.length_overflow = b_op_ff.overflow;
         end
         OP_READ: begin
            out_rsp.bin_count = b_op_ff.open_hit ? inc : cur;
         end
         default: begin
         end
      endcase
   end

   // Store write port: the clearing sweep first, then event records.
   always_comb begin
      ram_we = clr_busy_ff || (b_fire && b_op_ff.kind == OP_RECORD);
      ram_wa = clr_busy_ff ? clr_addr_ff : b_addr_ff;
      ram_wd = clr_busy_ff ? '0 : inc;
   end

   // Next values of the control state.
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(HIST_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
      if (b_load) begin
         b_valid_in = 1'b1;
      end else if (b_fire) begin
         b_valid_in = 1'b0;
      end else begin
         b_valid_in = b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         b_valid_ff  <= 1'b0;
         lw_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         b_valid_ff  <= b_valid_in;
         if (ram_we) begin
            lw_valid_ff <= 1'b1;
         end
      end
   end

   // Payload registers of the stage and of the last write.
   always_ff @(posedge clock) begin
      if (b_load) begin
         b_op_ff   <= mid_op;
         b_addr_ff <= mid_addr;
      end
      if (ram_we) begin
         lw_addr_ff <= ram_wa;
         lw_data_ff <= ram_wd;
      end
   end

endmodule

`default_nettype wire

// File: rtl/burst_duration_histogram.sv
// Top level of the burst duration histogram: front end, queues and back end.
// Requests pass the mid queue, the engine stage and the response queue.
// Throughput: one beat per cycle while no queue is full, set by the single
// histogram read-modify-write. Reset is synchronous; afterwards the store
// is cleared with req_full held high; csr writes are taken throughout.
`default_nettype none

module burst_duration_histogram #(
   parameter int HIST_DEPTH = 1024,
   parameter int MAX_REBIN  = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire bdh_pkg::req_type               req_data,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output bdh_pkg::rsp_type                    rsp_data,
   input  wire logic                           csr_write_en,
   input  wire bdh_pkg::csr_index_type         csr_index,
   input  wire logic [bdh_pkg::CSR_DATA_W-1:0] csr_data
);

   import bdh_pkg::*;

   localparam int AW        = $clog2(HIST_DEPTH);
   localparam int MID_W     = $bits(op_type) + AW;
   localparam int MID_DEPTH = 4;
   localparam int OUT_W     = $bits(rsp_type);
   localparam int OUT_DEPTH = 2;
   localparam logic [LENGTH_W-1:0] LAST_LEN = LENGTH_W'(HIST_DEPTH - 1);

   logic             accept;
   op_type           f_op;
   logic [AW-1:0]    f_addr;
   logic             mid_empty, mid_full, mid_pop;
   logic [MID_W-1:0] mid_data;
   op_type           mid_op;
   logic [AW-1:0]    mid_addr;
   logic             out_full, out_push;
   rsp_type          out_rsp;
   logic             clr_busy;

   assign req_full = mid_full || clr_busy;
   assign accept   = req_push && !req_full;

   bdh_front #(
      .HIST_DEPTH (HIST_DEPTH),
      .MAX_REBIN  (MAX_REBIN)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .accept       (accept),
      .req          (req_data),
      .op           (f_op),
      .op_addr      (f_addr)
   );

   // Queue between classification and the histogram engine.
   bdh_fifo #(
      .WIDTH (MID_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data ({f_op, f_addr}),
      .pop       (mid_pop),
      .pop_data  (mid_data),
      .empty     (mid_empty),
      .full      (mid_full)
   );

   assign mid_op   = op_type'(mid_data[MID_W-1:AW]);
   assign mid_addr = mid_data[AW-1:0];

   bdh_back #(
      .HIST_DEPTH (HIST_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_op    (mid_op),
      .mid_addr  (mid_addr),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_rsp   (out_rsp),
      .clr_busy  (clr_busy)
   );

   // Response queue parting the engine from the consumer.
   bdh_fifo #(
      .WIDTH (OUT_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_rsp),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty),
      .full      (out_full)
   );

`ifndef ASSERT_OFF
   // No beat enters or leaves while the store is being cleared.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> (req_full && rsp_empty && !out_push))
      else $error("beat moved during the clearing sweep");

   // The engine only hands over a beat when the response queue has room.
   a_out_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("response pushed into a full queue");

   // A closed event never carries a read count.
   a_done_no_count: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.event_done) |-> (rsp_data.bin_count == '0))
      else $error("event record with a non-zero count");

   // An overlong event is recorded in the last bin.
   a_overflow_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.length_overflow) |->
         (rsp_data.event_done && rsp_data.event_length == LAST_LEN))
      else $error("overflow flagged off the last bin");
`endif

endmodule

`default_nettype wire

// File: dv/bdh_scoreboard_pkg.sv
// Scoreboard and duration predictor for the burst duration histogram bench.
package bdh_scoreboard_pkg;

   import bdh_pkg::*;

   localparam int HIST_DEPTH   = 1024;
   localparam int MAX_REBIN    = 256;
   localparam int REPORT_LIMIT = 40;

   class duration_scoreboard;

      // Register copies and the running state of the aggregation.
      logic [REBIN_W-1:0]  rebin_setting;
      logic [THRESH_W-1:0] threshold_setting;
      logic [THRESH_W-1:0] aggregate_sum;
      int unsigned         bins_to_go;
      bit                  event_open;
      int unsigned         open_length;
      logic [COUNT_W-1:0]  length_counts [HIST_DEPTH];
      rsp_type             results_due [$];
      int unsigned         fail_count;

      function new();
         rebin_setting     = REBIN_W'(1);
         threshold_setting = '0;
         aggregate_sum     = '0;
         bins_to_go        = 1;
         event_open        = 1'b0;
         open_length       = 0;
         fail_count        = 0;
         foreach (length_counts[i]) length_counts[i] = '0;
      endfunction

      // Input bins per aggregate after the zero and upper limits are applied.
      function int unsigned aggregate_span();
         if (rebin_setting == 0) return 1;
         if (rebin_setting > MAX_REBIN) return MAX_REBIN;
         return rebin_setting;
      endfunction

      // Lengths beyond the store land in its last bin.
      function int unsigned hist_slot(input int unsigned length);
         return (length > HIST_DEPTH - 1) ? HIST_DEPTH - 1 : length;
      endfunction

      // A rebin write restarts the current aggregate but leaves an open event alone.
      function void apply_register(input csr_index_type index,
                                   input logic [CSR_DATA_W-1:0] value);
         if (index == CSR_REBIN_FACTOR) begin
            rebin_setting = value[REBIN_W-1:0];
            aggregate_sum = '0;
            bins_to_go    = aggregate_span();
         end else if (index == CSR_COUNT_THRESHOLD) begin
            threshold_setting = value[THRESH_W-1:0];
         end
      endfunction

      // Works out the response to one accepted request beat and queues it.
      function void predict_request(input req_type beat);
         rsp_type             due;
         logic [THRESH_W:0]   wide_sum;
         logic [COUNT_W:0]    total;
         int unsigned         slot;
         due = '0;
         if (beat.command == CMD_READ) begin
            // A read sees the open event as though it closed now.
            total = {1'b0, length_counts[beat.bin_index]};
            if (event_open && hist_slot(open_length) == beat.bin_index) total = total + 1;
            if (total > COUNT_MAX) total = {1'b0, COUNT_MAX};
            due.bin_count = total[COUNT_W-1:0];
         end else begin
            wide_sum      = aggregate_sum + beat.sample_count;
            aggregate_sum = (wide_sum > POOL_MAX) ? POOL_MAX : wide_sum[THRESH_W-1:0];
            if (bins_to_go > 0) bins_to_go--;
            if (bins_to_go == 0) begin
               // A complete aggregate either opens, closes or extends an event.
               if (!event_open && aggregate_sum > threshold_setting) begin
                  event_open  = 1'b1;
                  open_length = 0;
               end else if (event_open && aggregate_sum <= threshold_setting) begin
                  slot                = hist_slot(open_length);
                  due.event_done      = 1'b1;
                  due.event_length    = LENGTH_W'(slot);
                  due.length_overflow = (open_length > HIST_DEPTH - 1);
                  if (length_counts[slot] != COUNT_MAX)
                     length_counts[slot] = length_counts[slot] + 1;
                  event_open  = 1'b0;
                  open_length = 0;
               end
               if (event_open && open_length < HIST_DEPTH) open_length++;
               aggregate_sum = '0;
               bins_to_go    = aggregate_span();
            end
         end
         results_due.push_back(due);
      endfunction

      // Prints one line per mismatch, up to a limit, and counts them all.
      task report_mismatch(input string what);
         if (fail_count < REPORT_LIMIT) $display("mismatch: %s", what);
         fail_count++;
      endtask

      // Compares a response beat with the oldest outstanding prediction.
      task check_result(input rsp_type got);
         rsp_type want;
         if (results_due.size() == 0) begin
            report_mismatch("response beat with no request outstanding");
            return;
         end
         want = results_due.pop_front();
         if (got.event_done !== want.event_done)
            report_mismatch($sformatf("event_done got %0d, expected %0d",
                                      got.event_done, want.event_done));
         if (got.event_length !== want.event_length)
            report_mismatch($sformatf("event_length got %0d, expected %0d",
                                      got.event_length, want.event_length));
         if (got.length_overflow !== want.length_overflow)
            report_mismatch($sformatf("length_overflow got %0d, expected %0d",
                                      got.length_overflow, want.length_overflow));
         if (got.bin_count !== want.bin_count)
            report_mismatch($sformatf("bin_count got %0d, expected %0d",
                                      got.bin_count, want.bin_count));
      endtask

   endclass

endpackage

// File: dv/burst_duration_histogram_tb.sv
// Self-checking testbench for the burst duration histogram.
module burst_duration_histogram_tb;

   import bdh_pkg::*;
   import bdh_scoreboard_pkg::*;

   localparam int RUN_LIMIT  = 3_200_000;
   localparam int SAMPLE_TOP = 2 ** SAMPLE_W - 1;
   localparam int INDEX_TOP  = 2 ** INDEX_W - 1;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_push     = 1'b0;
   logic                  req_full;
   req_type               req_data     = '0;
   logic                  rsp_empty;
   logic                  rsp_pop      = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write_en = 1'b0;
   csr_index_type         csr_index    = CSR_REBIN_FACTOR;
   logic [CSR_DATA_W-1:0] csr_data     = '0;

   bit sender_no_gaps   = 1'b0;
   bit receiver_no_gaps = 1'b0;

   duration_scoreboard board = new();

   burst_duration_histogram #(
      .HIST_DEPTH (HIST_DEPTH),
      .MAX_REBIN  (MAX_REBIN)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #(RUN_LIMIT);
      $display("burst_duration_histogram regression: fail");
      $finish;
   end

   // Idle cycles before the next beat on either side.
   function automatic int draw_wait(input bit no_gaps);
      return no_gaps ? 0 : $urandom_range(0, 12);
   endfunction

   function automatic req_type sample_beat(input logic [SAMPLE_W-1:0] count);
      req_type beat;
      beat.command      = CMD_SAMPLE;
      beat.sample_count = count;
      beat.bin_index    = INDEX_W'($urandom);
      return beat;
   endfunction

   function automatic req_type read_beat(input logic [INDEX_W-1:0] slot);
      req_type beat;
      beat.command      = CMD_READ;
      beat.sample_count = SAMPLE_W'($urandom);
      beat.bin_index    = slot;
      return beat;
   endfunction

   // Offers one request beat and notes it once the block has taken it.
   task automatic send_request(input req_type beat);
      int gap;
      gap = draw_wait(sender_no_gaps);
      @(negedge clock);
      if (gap > 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push = 1'b1;
      req_data = beat;
      do begin
         @(posedge clock);
      end while (req_full);
      board.predict_request(beat);
   endtask

   // Stops offering beats and waits for every outstanding response.
   task automatic settle_pipeline();
      @(negedge clock);
      req_push = 1'b0;
      while (board.results_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = index;
      csr_data     = value;
      @(posedge clock);
      board.apply_register(index, value);
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // Bursty traffic: runs of counts above and below the per-bin threshold,
   // with some full-range noise and reads biased towards short lengths.
   task automatic run_phase(input logic [REBIN_W-1:0] rebin_raw,
                            input logic [THRESH_W-1:0] threshold, input int beats);
      int span;
      int low_ceiling;
      int high_floor;
      int pick;
      bit bursting;
      settle_pipeline();
      write_register(CSR_REBIN_FACTOR, CSR_DATA_W'(rebin_raw));
      write_register(CSR_COUNT_THRESHOLD, threshold);
      span = (rebin_raw == 0) ? 1 : ((rebin_raw > MAX_REBIN) ? MAX_REBIN : int'(rebin_raw));
      low_ceiling = int'(threshold) / span;
      if (low_ceiling > SAMPLE_TOP) low_ceiling = SAMPLE_TOP;
      high_floor = (low_ceiling < SAMPLE_TOP) ? low_ceiling + 1 : SAMPLE_TOP;
      sender_no_gaps = ($urandom_range(0, 3) == 0);
      bursting = 1'b0;
      for (int i = 0; i < beats; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 15)
            send_request(read_beat(($urandom_range(0, 3) != 0) ?
                                   INDEX_W'($urandom_range(0, 15)) : INDEX_W'($urandom)));
         else if (pick < 20)
            send_request(sample_beat(SAMPLE_W'($urandom)));
         else if (bursting)
            send_request(sample_beat(SAMPLE_W'($urandom_range(high_floor, SAMPLE_TOP))));
         else
            send_request(sample_beat(SAMPLE_W'($urandom_range(0, low_ceiling))));
         if ($urandom_range(0, 3 * span) == 0) bursting = !bursting;
      end
   endtask

   // Response side: pops with random stalls and checks every beat taken.
   initial begin : result_sink
      int stall;
      int unsigned taken;
      taken = 0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         stall = draw_wait(receiver_no_gaps);
         if (stall > 0) begin
            rsp_pop = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop = 1'b1;
         do begin
            @(posedge clock);
         end while (rsp_empty);
         board.check_result(rsp_data);
         taken++;
         if (taken % 64 == 0) receiver_no_gaps = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: any nonzero bin opens an event, a zero bin closes it.
      send_request(read_beat(INDEX_W'(0)));
      send_request(read_beat(INDEX_W'(INDEX_TOP)));
      send_request(sample_beat(SAMPLE_W'(0)));
      send_request(sample_beat(SAMPLE_W'(SAMPLE_TOP)));
      send_request(read_beat(INDEX_W'(1)));
      send_request(sample_beat(SAMPLE_W'(1)));
      send_request(sample_beat(SAMPLE_W'(0)));
      send_request(read_beat(INDEX_W'(2)));
      send_request(sample_beat(SAMPLE_W'(7)));
      send_request(sample_beat(SAMPLE_W'(0)));
      send_request(sample_beat(SAMPLE_W'(0)));

      // Pairs of bins against a small threshold; the event is left open.
      settle_pipeline();
      write_register(CSR_REBIN_FACTOR, CSR_DATA_W'(2));
      write_register(CSR_COUNT_THRESHOLD, CSR_DATA_W'(10));
      send_request(sample_beat(SAMPLE_W'(6)));
      send_request(sample_beat(SAMPLE_W'(5)));
      send_request(sample_beat(SAMPLE_W'(SAMPLE_TOP)));
      send_request(sample_beat(SAMPLE_W'(0)));

      // Changing the rebin factor mid-event restarts the aggregate only;
      // an aggregate equal to the threshold closes the event.
      settle_pipeline();
      write_register(CSR_REBIN_FACTOR, CSR_DATA_W'(3));
      send_request(sample_beat(SAMPLE_W'(3)));
      send_request(sample_beat(SAMPLE_W'(3)));
      send_request(sample_beat(SAMPLE_W'(4)));
      send_request(read_beat(INDEX_W'(2)));
      send_request(read_beat(INDEX_W'(0)));
      repeat (3) send_request(sample_beat(SAMPLE_W'(SAMPLE_TOP)));
      send_request(read_beat(INDEX_W'(0)));
      send_request(read_beat(INDEX_W'(1)));

      // An event longer than the store: it saturates, lands in the last bin
      // and flags the overflow.
      settle_pipeline();
      write_register(CSR_REBIN_FACTOR, CSR_DATA_W'(1));
      write_register(CSR_COUNT_THRESHOLD, CSR_DATA_W'(16383));
      sender_no_gaps = 1'b1;
      for (int i = 0; i < 1040; i++) begin
         if (i % 150 == 149)
            send_request(read_beat(INDEX_W'($urandom_range(1000, INDEX_TOP))));
         else
            send_request(sample_beat(SAMPLE_W'($urandom_range(16384, SAMPLE_TOP))));
      end
      send_request(read_beat(INDEX_W'(INDEX_TOP)));
      send_request(sample_beat(SAMPLE_W'(0)));
      send_request(read_beat(INDEX_W'(INDEX_TOP)));

      // Random phases across the register range, extremes included.
      run_phase(REBIN_W'(1), THRESH_W'(0), 60);
      run_phase(REBIN_W'(3), THRESH_W'(4500), 50);
      run_phase(REBIN_W'(0), THRESH_W'(1000), 40);
      run_phase(REBIN_W'(511), POOL_MAX, 20);
      run_phase(REBIN_W'(256), THRESH_W'(0), 130);
      repeat (2)
         run_phase(REBIN_W'($urandom_range(1, 8)), THRESH_W'($urandom_range(0, 20000)), 40);

      settle_pipeline();
      repeat (8) @(posedge clock);
      if (board.fail_count == 0)
         $display("burst_duration_histogram regression: pass");
      else
         $display("burst_duration_histogram regression: fail");
      $finish;
   end

endmodule

// File: files.f
rtl/bdh_pkg.sv
rtl/bdh_ram.sv
rtl/bdh_fifo.sv
rtl/bdh_front.sv
rtl/bdh_back.sv
rtl/burst_duration_histogram.sv
dv/bdh_scoreboard_pkg.sv
dv/burst_duration_histogram_tb.sv
